/* design/sss_pkg.sv */
package sss_pkg;

  localparam int unsigned SideBins = 64;
  localparam int unsigned BinCount = 2 * SideBins + 1;
  localparam int unsigned BinW     = 9;
  localparam int unsigned AddrW    = $clog2(BinCount);

  localparam logic [BinW-1:0] BinIdle     = 9'd511;
  localparam logic [7:0]      RssiFloor   = 8'd26;
  localparam logic [7:0]      SpanMin     = 8'd80;
  localparam logic [7:0]      PauseAfterTx = 8'd100;
  localparam logic [7:0]      PauseCarrier = 8'd40;
  localparam logic [7:0]      PauseSweep   = 8'd10;
  localparam logic [5:0]      DrawPeriod   = 6'd20;
  localparam logic [5:0]      SettleTicks  = 6'd3;

  // configuration register indexes
  localparam logic [2:0] RegPanOn   = 3'd0;
  localparam logic [2:0] RegCenter  = 3'd1;
  localparam logic [2:0] RegStep    = 3'd2;
  localparam logic [2:0] RegStepMin = 3'd3;
  localparam logic [2:0] RegStepMax = 3'd4;

  // commands from controller to datapath
  typedef struct packed {
    logic             clear;      // start clear sweep of store
    logic             mul_start;  // start tune frequency multiply
    logic [BinW-1:0]  mul_idx;
    logic             wr;         // store write
    logic [AddrW-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             scan_mm;    // start min/max scan
    logic             scan_pk;    // start peak scan
  } dp_cmd_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] freq;
    logic [7:0]  max_lvl;
    logic [7:0]  min_lvl;
    logic [31:0] peak;
  } dp_sts_t;

  function automatic logic [7:0] clamp_rssi(input logic [8:0] v);
    logic [7:0] r;
    begin
      if (v > 9'd255) r = 8'd255;
      else if (v[7:0] < RssiFloor) r = RssiFloor;
      else r = v[7:0];
      return r;
    end
  endfunction

endpackage

/* design/spectrum_sweep_sequencer_core.sv */
// channel | direction | handshake              | payload
// config  | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
// item in | in        | in_valid_i / in_stall_o| tick flags and two RSSI readings
// result  | out       | out_valid_o/out_stall_i| tune, draw, status, levels, peak
// A plain tick goes straight to the result; a tune tick waits for one multiply in the datapath.
// A pause tick rescans the store once; a multiply follows when it tunes.
// A sweep-end tick walks the 129-entry store twice.
// After reset the store is zeroed, one entry a cycle, and no item is taken meanwhile.
// A result waits in its register while out_stall_i is high; no new item meanwhile.
module spectrum_sweep_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        blocked_i,
  input  logic        transmitting_i,
  input  logic        monitoring_i,
  input  logic        squelch_open_i,
  input  logic [8:0]  center_rssi_i,
  input  logic [8:0]  sweep_rssi_i,
  input  logic        display_suppressed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tune_valid_o,
  output logic [31:0] tune_freq_o,
  output logic        draw_request_o,
  output logic        screen_update_o,
  output logic        pan_enabled_o,
  output logic        sweeping_o,
  output logic [7:0]  rssi_max_o,
  output logic [7:0]  rssi_min_o,
  output logic [31:0] peak_freq_o,
  output logic [31:0] sweep_count_o
);
  import sss_pkg::*;

  logic        pan_on_q;
  logic [31:0] center_q, step_q, smin_q, smax_q, step_eff;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_on_q <= 1'b0; center_q <= '0;
      step_q <= 32'd1250; smin_q <= 32'd125; smax_q <= 32'd2500;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPanOn:   pan_on_q <= cfg_data_i[0];
        RegCenter:  center_q <= cfg_data_i;
        RegStep:    step_q   <= cfg_data_i;
        RegStepMin: smin_q   <= cfg_data_i;
        RegStepMax: smax_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign step_eff = (step_q < smin_q) ? smin_q : ((step_q > smax_q) ? smax_q : step_q);

  sss_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .pan_on_i(pan_on_q), .center_freq_i(center_q),
    .in_valid_i, .in_stall_o,
    .blocked_i, .transmitting_i, .monitoring_i, .squelch_open_i,
    .center_rssi_i, .sweep_rssi_i, .display_suppressed_i,
    .out_valid_o, .out_stall_i,
    .tune_valid_o, .tune_freq_o, .draw_request_o, .screen_update_o,
    .pan_enabled_o, .sweeping_o, .rssi_max_o, .rssi_min_o,
    .peak_freq_o, .sweep_count_o,
    .cmd_o(cmd), .sts_i(sts)
  );

  sss_datapath u_dp (
    .clk_i, .rst_ni,
    .center_freq_i(center_q), .step_i(step_eff),
    .cmd_i(cmd), .sts_o(sts)
  );

endmodule

/* design/sss_datapath.sv */
module sss_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [31:0]            center_freq_i,
  input  logic [31:0]            step_i,
  input  sss_pkg::dp_cmd_t       cmd_i,
  output sss_pkg::dp_sts_t       sts_o
);
  import sss_pkg::*;

  typedef enum logic [5:0] {
    DpIdle  = 6'b000001,
    DpClr   = 6'b000010,
    DpMul   = 6'b000100,
    DpMm    = 6'b001000,
    DpPk    = 6'b010000,
    DpPkF   = 6'b100000
  } dp_state_e;

  dp_state_e state_q, state_d;

  logic [7:0]       mem [BinCount];
  logic [7:0]       rd_q;
  logic [AddrW:0]   addr_q, addr_d;   // read address being issued
  logic [AddrW:0]   seen_q, seen_d;   // index of data in rd_q
  logic             rdv_q, rdv_d;
  logic [AddrW-1:0] rd_addr;
  logic             mem_we;
  logic [AddrW-1:0] mem_wa;
  logic [7:0]       mem_wd;

  logic [7:0]  hi_q, hi_d, lo_q, lo_d, thr_q, thr_d, best_q, best_d;
  logic [AddrW-1:0] bidx_q, bidx_d;
  logic        found_q, found_d;
  logic        pkreq_q, pkreq_d;  // peak scan follows the min/max scan
  logic [31:0] freq_q, freq_d, peak_q, peak_d;
  logic [BinW-1:0] midx_q, midx_d;
  logic        mfin_q, mfin_d;   // multiply is for peak result
  logic [7:0]  span;
  logic [AddrW-1:0] off;
  logic        neg;
  logic [63:0] prod;
  logic        excl;

  assign rd_addr = addr_q[AddrW-1:0];
  assign span = (hi_q - lo_q) < SpanMin ? SpanMin : (hi_q - lo_q);

  // offset magnitude from center, multiplied by the step combinationally
  always_comb begin
    if (midx_q >= BinW'(SideBins)) begin
      neg = 1'b0;
      off = AddrW'(midx_q - BinW'(SideBins));
    end else begin
      neg = 1'b1;
      off = AddrW'(BinW'(SideBins) - midx_q);
    end
    prod = 64'(step_i) * 64'(off);
  end

  assign excl = !((32'(seen_q) + 32'd1 < 32'(SideBins)) ||
                  (32'(seen_q) > 32'(SideBins) + 32'd1));

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    seen_d  = seen_q;
    rdv_d   = 1'b0;
    hi_d = hi_q; lo_d = lo_q; thr_d = thr_q; best_d = best_q;
    bidx_d = bidx_q; found_d = found_q; pkreq_d = pkreq_q;
    freq_d = freq_q; peak_d = peak_q;
    midx_d = midx_q; mfin_d = mfin_q;
    mem_we = cmd_i.wr;
    mem_wa = cmd_i.wr_addr;
    mem_wd = cmd_i.wr_data;
    unique case (state_q)
      DpIdle: begin
        if (cmd_i.clear) begin
          state_d = DpClr;
          addr_d  = '0;
        end else if (cmd_i.mul_start) begin
          state_d = DpMul;
          midx_d  = cmd_i.mul_idx;
          mfin_d  = 1'b0;
        end else if (cmd_i.scan_mm || cmd_i.scan_pk) begin
          state_d = cmd_i.scan_mm ? DpMm : DpPk;
          pkreq_d = cmd_i.scan_mm && cmd_i.scan_pk;
          addr_d  = '0;
          best_d  = '0;
          found_d = 1'b0;
          thr_d   = lo_q + {2'b00, span[7:2]};
        end
      end
      DpClr: begin
        mem_we = 1'b1;
        mem_wa = rd_addr;
        mem_wd = '0;
        addr_d = addr_q + 1'b1;
        if (addr_q == (AddrW+1)'(BinCount - 1)) state_d = DpIdle;
      end
      DpMul: begin
        freq_d = neg ? center_freq_i - prod[31:0] : center_freq_i + prod[31:0];
        if (mfin_q) peak_d = center_freq_i + (neg ? -prod[31:0] : prod[31:0]);
        state_d = DpIdle;
      end
      DpMm, DpPk: begin
        // one read issued per cycle, its result checked in the following cycle
        if (addr_q < (AddrW+1)'(BinCount)) begin
          rdv_d  = 1'b1;
          seen_d = addr_q;
          addr_d = addr_q + 1'b1;
        end
        if (rdv_q) begin
          if (state_q == DpMm) begin
            if (seen_q == '0) begin
              hi_d = rd_q; lo_d = rd_q;
            end else begin
              if (rd_q > hi_q) hi_d = rd_q;
              if (rd_q < lo_q) lo_d = rd_q;
            end
          end else if (best_q < rd_q && rd_q >= thr_q && !excl) begin
            best_d = rd_q; bidx_d = seen_q[AddrW-1:0]; found_d = 1'b1;
          end
        end
        if (!rdv_q && addr_q == (AddrW+1)'(BinCount)) begin
          if (state_q == DpMm) begin
            state_d = pkreq_q ? DpPk : DpIdle;
            pkreq_d = 1'b0;
            addr_d  = '0;
            best_d  = '0;
            found_d = 1'b0;
            thr_d   = lo_q + {2'b00, span[7:2]};
          end else state_d = DpPkF;
        end
      end
      DpPkF: begin
        if (found_q) begin
          state_d = DpMul;
          midx_d  = BinW'(bidx_q);
          mfin_d  = 1'b1;
        end else begin
          peak_d  = '0;
          state_d = DpIdle;
        end
      end
      default: state_d = DpIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[rd_addr < AddrW'(BinCount) ? rd_addr : '0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DpClr;
      addr_q <= '0; seen_q <= '0; rdv_q <= 1'b0;
      hi_q <= '0; lo_q <= '0; thr_q <= '0; best_q <= '0;
      bidx_q <= '0; found_q <= 1'b0; freq_q <= '0; peak_q <= '0;
      midx_q <= '0; mfin_q <= 1'b0; pkreq_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q <= addr_d; seen_q <= seen_d; rdv_q <= rdv_d;
      hi_q <= hi_d; lo_q <= lo_d; thr_q <= thr_d; best_q <= best_d;
      bidx_q <= bidx_d; found_q <= found_d; freq_q <= freq_d; peak_q <= peak_d;
      midx_q <= midx_d; mfin_q <= mfin_d; pkreq_q <= pkreq_d;
    end
  end

  assign sts_o.busy    = (state_q != DpIdle);
  assign sts_o.freq    = freq_q;
  assign sts_o.max_lvl = hi_q;
  assign sts_o.min_lvl = lo_q;
  assign sts_o.peak    = peak_q;

  // minimum never exceeds maximum when a min/max scan ends in idle
  a_minmax: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DpIdle && $past(state_q) == DpMm) |-> lo_q <= hi_q)
    else $error("min above max");
  a_clr_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DpClr && addr_q == (AddrW+1)'(BinCount - 1)) |=> state_q == DpIdle)
    else $error("clear sweep overrun");
  a_mul_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == DpMul |=> state_q == DpIdle)
    else $error("multiply took more than one cycle");

endmodule

/* design/sss_ctrl.sv */
module sss_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pan_on_i,
  input  logic [31:0]            center_freq_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   blocked_i,
  input  logic                   transmitting_i,
  input  logic                   monitoring_i,
  input  logic                   squelch_open_i,
  input  logic [8:0]             center_rssi_i,
  input  logic [8:0]             sweep_rssi_i,
  input  logic                   display_suppressed_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   tune_valid_o,
  output logic [31:0]            tune_freq_o,
  output logic                   draw_request_o,
  output logic                   screen_update_o,
  output logic                   pan_enabled_o,
  output logic                   sweeping_o,
  output logic [7:0]             rssi_max_o,
  output logic [7:0]             rssi_min_o,
  output logic [31:0]            peak_freq_o,
  output logic [31:0]            sweep_count_o,
  output sss_pkg::dp_cmd_t       cmd_o,
  input  sss_pkg::dp_sts_t       sts_i
);
  import sss_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StWait = 4'b0010,   // datapath working for this item
    StFin  = 4'b0100,   // start tune multiply once the scan is done
    StOut  = 4'b1000
  } st_e;

  st_e st_q, st_d;
  logic        active_q, active_d;
  logic [7:0]  pause_q, pause_d;
  logic [BinW-1:0] bin_q, bin_d;
  logic [5:0]  settle_q, settle_d;
  logic [31:0] sweeps_q, sweeps_d;
  logic        tv_q, tv_d, tfc_q, tfc_d, draw_q, draw_d, upd_q, upd_d;
  logic        oval_q, oval_d;
  logic [31:0] tf_q, tf_d;
  logic        take;
  dp_cmd_t     cmd;
  logic [7:0]  p1;

  assign in_stall_o = (st_q != StIdle) || sts_i.busy || oval_q;
  assign take = in_valid_i && !in_stall_o;

  always_comb begin
    st_d = st_q; active_d = active_q; pause_d = pause_q; bin_d = bin_q;
    settle_d = settle_q; sweeps_d = sweeps_q;
    tv_d = tv_q; tfc_d = tfc_q; tf_d = tf_q; draw_d = draw_q; upd_d = upd_q;
    oval_d = oval_q && out_stall_i;
    cmd = '0;
    p1 = '0;
    unique case (st_q)
      StIdle: if (take) begin
        tv_d = 1'b0; tfc_d = 1'b0; tf_d = '0; draw_d = 1'b0; upd_d = 1'b0;
        st_d = StOut;
        if (!pan_on_i || blocked_i) begin
          if (active_q) begin
            active_d = 1'b0; sweeps_d = '0; bin_d = '0; settle_d = SettleTicks;
            if (!transmitting_i) begin tv_d = 1'b1; tf_d = center_freq_i; end
            upd_d = 1'b1;
          end
        end else if (transmitting_i || monitoring_i) begin
          bin_d = BinIdle;
        end else if (!active_q) begin
          bin_d = '0; settle_d = SettleTicks; pause_d = '0; active_d = 1'b1;
          upd_d = 1'b1; tv_d = 1'b1; tfc_d = 1'b1;
          cmd.mul_start = 1'b1; cmd.mul_idx = '0;
          st_d = StWait;
        end else if (bin_q >= BinW'(BinCount)) begin
          pause_d = PauseAfterTx; bin_d = '0; settle_d = SettleTicks;
        end else if (pause_q != 0) begin
          cmd.wr = 1'b1; cmd.wr_addr = AddrW'(SideBins);
          cmd.wr_data = clamp_rssi(center_rssi_i);
          cmd.scan_mm = 1'b1;
          st_d = StWait;
          p1 = squelch_open_i ? PauseCarrier : pause_q - 8'd1;
          pause_d = p1;
          if (p1 != 0) begin
            if (settle_q <= 6'd1) begin
              settle_d = DrawPeriod;
              draw_d = !display_suppressed_i;
            end else settle_d = settle_q - 6'd1;
          end else begin
            // pause ends: tune current bin; the first settle tick passes at once
            tv_d = 1'b1; tfc_d = 1'b1; settle_d = SettleTicks - 6'd1;
            st_d = StFin;  // multiply after scan completes
          end
        end else if (settle_q >= 6'd1) begin
          settle_d = settle_q - 6'd1;
        end else begin
          cmd.wr = 1'b1; cmd.wr_addr = AddrW'(bin_q);
          cmd.wr_data = clamp_rssi(sweep_rssi_i);
          tv_d = 1'b1;
          if (bin_q + 1'b1 >= BinW'(BinCount)) begin
            bin_d = '0; settle_d = SettleTicks; pause_d = PauseSweep;
            tf_d = center_freq_i;
            if (sweeps_q != '1) sweeps_d = sweeps_q + 32'd1;
            cmd.scan_mm = 1'b1; cmd.scan_pk = 1'b1;
            draw_d = !display_suppressed_i;
            st_d = StWait;
          end else begin
            bin_d = bin_q + 1'b1; pause_d = '0; tfc_d = 1'b1;
            cmd.mul_start = 1'b1; cmd.mul_idx = bin_q + 1'b1;
            st_d = StWait;
          end
        end
      end
      StFin: if (!sts_i.busy) begin
        cmd.mul_start = 1'b1; cmd.mul_idx = bin_q;
        st_d = StWait;
      end
      StWait: if (!sts_i.busy) st_d = StOut;
      StOut: begin
        if (tfc_q) tf_d = sts_i.freq;
        oval_d = 1'b1;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; active_q <= 1'b0; pause_q <= '0; bin_q <= '0;
      settle_q <= '0; sweeps_q <= '0; tv_q <= 1'b0; tfc_q <= 1'b0;
      tf_q <= '0; draw_q <= 1'b0; upd_q <= 1'b0; oval_q <= 1'b0;
    end else begin
      st_q <= st_d; active_q <= active_d; pause_q <= pause_d; bin_q <= bin_d;
      settle_q <= settle_d; sweeps_q <= sweeps_d; tv_q <= tv_d; tfc_q <= tfc_d;
      tf_q <= tf_d; draw_q <= draw_d; upd_q <= upd_d; oval_q <= oval_d;
    end
  end

  assign cmd_o = cmd;
  assign out_valid_o    = oval_q;
  assign tune_valid_o   = tv_q;
  assign tune_freq_o    = tf_q;
  assign draw_request_o = draw_q;
  assign screen_update_o = upd_q;
  assign pan_enabled_o  = active_q;
  assign sweeping_o     = pan_on_i && active_q && (pause_q == 0);
  assign rssi_max_o     = sts_i.max_lvl;
  assign rssi_min_o     = sts_i.min_lvl;
  assign peak_freq_o    = sts_i.peak;
  assign sweep_count_o  = sweeps_q;

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> !sts_i.busy && !oval_q)
    else $error("item taken while busy");
  a_out_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StOut |=> oval_q)
    else $error("result not presented");
  a_tv_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oval_q && !tv_q) |-> tf_q == '0)
    else $error("tune freq nonzero without tune");

endmodule
